// File: design/ncc_pkg.sv
// shared constants, codes and control types for the nearest centroid classifier
// no dependencies; used by ncc_ctrl, ncc_dpath and nearest_centroid_classifier_top

package ncc_pkg;

    localparam int MAX_CLASSES_DEF    = 16;
    localparam int MAX_COMPONENTS_DEF = 4;
    localparam int SAMPLE_BITS_DEF    = 16;

    localparam int FIELD_W     = 16;
    localparam int IN_COMPS    = 4;
    localparam int LABEL_W     = 4;
    localparam int INDEX_W     = 4;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 5;
    localparam int CLASS_CNT_W = 5;
    localparam int COMP_CNT_W  = 3;

    localparam logic [COMP_CNT_W-1:0] COMP_CNT_RESET = 3'd4;

    localparam logic OP_CLASSIFY = 1'b0;
    localparam logic OP_LOAD     = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_CLASS_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COMP_COUNT  = 2'd1;

    typedef struct packed {
        logic start;
        logic load;
        logic issue;
        logic result;
    } t_cmd;

    typedef struct packed {
        logic busy;
    } t_status;

endpackage

// File: design/ncc_dpath.sv
// datapath: centroid memory, distance pipeline and running minimum
// depends on ncc_pkg; driven by ncc_ctrl through t_cmd, read address and component count

module ncc_dpath #(
    parameter int MAX_CLASSES    = ncc_pkg::MAX_CLASSES_DEF,
    parameter int MAX_COMPONENTS = ncc_pkg::MAX_COMPONENTS_DEF,
    parameter int SAMPLE_BITS    = ncc_pkg::SAMPLE_BITS_DEF,
    parameter int AW             = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1,
    parameter int CMP_W          = $clog2(MAX_COMPONENTS + 1)
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  ncc_pkg::t_cmd                         i_cmd,
    input  logic [AW-1:0]                         i_rd_addr,
    input  logic [CMP_W-1:0]                      i_comps,
    input  logic [ncc_pkg::INDEX_W-1:0]           i_class_index,
    input  logic signed [ncc_pkg::FIELD_W-1:0]    i_comp0,
    input  logic signed [ncc_pkg::FIELD_W-1:0]    i_comp1,
    input  logic signed [ncc_pkg::FIELD_W-1:0]    i_comp2,
    input  logic signed [ncc_pkg::FIELD_W-1:0]    i_comp3,
    output ncc_pkg::t_status                      o_stat,
    output logic [ncc_pkg::LABEL_W-1:0]           o_class_label
);

    localparam int EFF_W = (SAMPLE_BITS < ncc_pkg::FIELD_W) ? SAMPLE_BITS : ncc_pkg::FIELD_W;
    localparam int SQ_W  = 2 * EFF_W;
    localparam int SUM_W = SQ_W + $clog2(MAX_COMPONENTS + 1);
    localparam int VEC_W = MAX_COMPONENTS * EFF_W;

    logic signed [ncc_pkg::FIELD_W-1:0] w_in [ncc_pkg::IN_COMPS];
    logic [VEC_W-1:0]                   w_vec;
    logic                               w_load_ok;

    logic [VEC_W-1:0]    r_mem [MAX_CLASSES];
    logic [VEC_W-1:0]    r_pix;
    logic [VEC_W-1:0]    r_rd;
    logic                r_s1_valid;
    logic [AW-1:0]       r_s1_idx;
    logic [SQ_W-1:0]     r_sq [MAX_COMPONENTS];
    logic                r_s2_valid;
    logic [AW-1:0]       r_s2_idx;
    logic [SUM_W-1:0]    r_sum;
    logic                r_s3_valid;
    logic [AW-1:0]       r_s3_idx;
    logic [SUM_W-1:0]    r_best_d;
    logic [AW-1:0]       r_best_idx;
    logic                r_first;
    logic [ncc_pkg::LABEL_W-1:0] r_label;

    logic [SQ_W-1:0]     n_sq [MAX_COMPONENTS];
    logic [SUM_W-1:0]    n_sum;

    assign w_in[0] = i_comp0;
    assign w_in[1] = i_comp1;
    assign w_in[2] = i_comp2;
    assign w_in[3] = i_comp3;

    // low sample bits of each field; components past the input fields are zero
    for (genvar j = 0; j < MAX_COMPONENTS; j++) begin : g_vec
        if (j < ncc_pkg::IN_COMPS) begin : g_used
            assign w_vec[j*EFF_W +: EFF_W] = w_in[j][EFF_W-1:0];
        end else begin : g_zero
            assign w_vec[j*EFF_W +: EFF_W] = '0;
        end
    end

    assign w_load_ok = (32'(i_class_index) < MAX_CLASSES);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && w_load_ok) begin
            r_mem[AW'(i_class_index)] <= w_vec;
        end
        r_rd <= r_mem[i_rd_addr];
    end

    // squared difference per component, masked by the active component count
    always_comb begin
        logic signed [EFF_W:0] d;
        logic [EFF_W:0]        m;
        for (int j = 0; j < MAX_COMPONENTS; j++) begin
            d = $signed({r_pix[j*EFF_W + EFF_W - 1], r_pix[j*EFF_W +: EFF_W]})
              - $signed({r_rd[j*EFF_W + EFF_W - 1], r_rd[j*EFF_W +: EFF_W]});
            m = d[EFF_W] ? (EFF_W + 1)'(-d) : (EFF_W + 1)'(d);
            if (CMP_W'(j) < i_comps) begin
                n_sq[j] = m[EFF_W-1:0] * m[EFF_W-1:0];
            end else begin
                n_sq[j] = '0;
            end
        end
    end

    always_comb begin
        n_sum = '0;
        for (int j = 0; j < MAX_COMPONENTS; j++) begin
            n_sum = n_sum + SUM_W'(r_sq[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_pix <= w_vec;
        end
        r_s1_idx <= i_rd_addr;
        for (int j = 0; j < MAX_COMPONENTS; j++) begin
            r_sq[j] <= n_sq[j];
        end
        r_s2_idx <= r_s1_idx;
        r_sum    <= n_sum;
        r_s3_idx <= r_s2_idx;
        if (i_cmd.result) begin
            r_label <= ncc_pkg::LABEL_W'(r_best_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_first    <= 1'b1;
            r_best_idx <= '0;
            r_best_d   <= '0;
        end else begin
            r_s1_valid <= i_cmd.issue;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            if (i_cmd.start) begin
                r_first    <= 1'b1;
                r_best_idx <= '0;
            end else if (r_s3_valid && (r_first || (r_sum < r_best_d))) begin
                // strict less keeps the lower label on a tie
                r_first    <= 1'b0;
                r_best_d   <= r_sum;
                r_best_idx <= r_s3_idx;
            end
        end
    end

    assign o_stat.busy   = r_s1_valid | r_s2_valid | r_s3_valid;
    assign o_class_label = r_label;

endmodule

// File: design/ncc_ctrl.sv
// controller: configuration registers, request handshakes and class sweep sequencer
// depends on ncc_pkg; commands ncc_dpath through t_cmd, reads t_status back

module ncc_ctrl #(
    parameter int MAX_CLASSES    = ncc_pkg::MAX_CLASSES_DEF,
    parameter int MAX_COMPONENTS = ncc_pkg::MAX_COMPONENTS_DEF,
    parameter int AW             = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1,
    parameter int CMP_W          = $clog2(MAX_COMPONENTS + 1)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_operation,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ncc_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [ncc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  ncc_pkg::t_status                    i_stat,
    output ncc_pkg::t_cmd                       o_cmd,
    output logic [AW-1:0]                       o_rd_addr,
    output logic [CMP_W-1:0]                    o_comps
);

    localparam int CNT_W = $clog2(MAX_CLASSES + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_state;

    t_state                                r_state, n_state;
    logic [AW-1:0]                         r_k, n_k;
    logic                                  r_out_valid, n_out_valid;
    logic [ncc_pkg::CLASS_CNT_W-1:0]       r_class_count, n_class_count;
    logic [ncc_pkg::COMP_CNT_W-1:0]        r_comp_count, n_comp_count;
    logic [CNT_W-1:0]                      w_n;
    logic                                  w_in_acc;
    logic                                  w_slot_free;

    assign w_n = (32'(r_class_count) > MAX_CLASSES) ? CNT_W'(MAX_CLASSES)
                                                    : CNT_W'(r_class_count);
    assign o_comps = (32'(r_comp_count) > MAX_COMPONENTS) ? CMP_W'(MAX_COMPONENTS)
                                                          : CMP_W'(r_comp_count);

    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_in_acc    = i_in_valid & o_in_ready;
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_rd_addr   = r_k;

    always_comb begin
        n_state       = r_state;
        n_k           = r_k;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_class_count = r_class_count;
        n_comp_count  = r_comp_count;
        o_cmd         = '0;

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ncc_pkg::CFG_CLASS_COUNT: n_class_count = i_cfg_data[ncc_pkg::CLASS_CNT_W-1:0];
                ncc_pkg::CFG_COMP_COUNT:  n_comp_count  = i_cfg_data[ncc_pkg::COMP_CNT_W-1:0];
                default: ;
            endcase
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_operation == ncc_pkg::OP_LOAD) begin
                        o_cmd.load = 1'b1;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_k         = '0;
                        n_state     = (w_n == '0) ? ST_DRAIN : ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                o_cmd.issue = 1'b1;
                if (CNT_W'(r_k) == w_n - CNT_W'(1)) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_k = r_k + AW'(1);
                end
            end
            ST_DRAIN: begin
                if (!i_stat.busy && w_slot_free) begin
                    o_cmd.result = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_k           <= '0;
            r_out_valid   <= 1'b0;
            r_class_count <= '0;
            r_comp_count  <= ncc_pkg::COMP_CNT_RESET;
        end else begin
            r_state       <= n_state;
            r_k           <= n_k;
            r_out_valid   <= n_out_valid;
            r_class_count <= n_class_count;
            r_comp_count  <= n_comp_count;
        end
    end

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |-> !i_stat.busy)
        else $error("new request started while distance pipeline busy");

    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && CNT_W'(r_k) == w_n - CNT_W'(1)) |=> r_state == ST_DRAIN)
        else $error("class sweep did not stop at last class");

    a_result_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.result |=> (r_out_valid && r_state == ST_IDLE))
        else $error("result not presented after sweep");

endmodule

// File: design/nearest_centroid_classifier_top.sv
// top level of the nearest centroid classifier
// depends on ncc_pkg, ncc_ctrl and ncc_dpath
//
// channel   direction  handshake                   payload
// in        request    i_in_valid / o_in_ready     i_operation i_class_index i_comp0..3
// out       result     o_out_valid / i_out_ready   o_class_label
// cfg       write      i_cfg_valid / o_cfg_ready   i_cfg_index i_cfg_data
//
// a load request writes the centroid memory when it is accepted; a classify request sweeps
// the first n classes, n the saturated class count, with one centroid memory read per cycle
// feeding a three-stage distance pipeline (registered read, squares, sum) and a compare
// the result register lets a new request in while the last label waits on out
// synchronous active-low reset; the centroid memory has no reset and no clearing pass

module nearest_centroid_classifier_top #(
    parameter int MAX_CLASSES    = ncc_pkg::MAX_CLASSES_DEF,
    parameter int MAX_COMPONENTS = ncc_pkg::MAX_COMPONENTS_DEF,
    parameter int SAMPLE_BITS    = ncc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_operation,
    input  logic [ncc_pkg::INDEX_W-1:0]         i_class_index,
    input  logic signed [ncc_pkg::FIELD_W-1:0]  i_comp0,
    input  logic signed [ncc_pkg::FIELD_W-1:0]  i_comp1,
    input  logic signed [ncc_pkg::FIELD_W-1:0]  i_comp2,
    input  logic signed [ncc_pkg::FIELD_W-1:0]  i_comp3,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [ncc_pkg::LABEL_W-1:0]         o_class_label,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ncc_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [ncc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int AW    = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int CMP_W = $clog2(MAX_COMPONENTS + 1);

    ncc_pkg::t_cmd    w_cmd;
    ncc_pkg::t_status w_stat;
    logic [AW-1:0]    w_rd_addr;
    logic [CMP_W-1:0] w_comps;

    ncc_ctrl #(
        .MAX_CLASSES    (MAX_CLASSES),
        .MAX_COMPONENTS (MAX_COMPONENTS),
        .AW             (AW),
        .CMP_W          (CMP_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_rd_addr   (w_rd_addr),
        .o_comps     (w_comps)
    );

    ncc_dpath #(
        .MAX_CLASSES    (MAX_CLASSES),
        .MAX_COMPONENTS (MAX_COMPONENTS),
        .SAMPLE_BITS    (SAMPLE_BITS),
        .AW             (AW),
        .CMP_W          (CMP_W)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_rd_addr     (w_rd_addr),
        .i_comps       (w_comps),
        .i_class_index (i_class_index),
        .i_comp0       (i_comp0),
        .i_comp1       (i_comp1),
        .i_comp2       (i_comp2),
        .i_comp3       (i_comp3),
        .o_stat        (w_stat),
        .o_class_label (o_class_label)
    );

endmodule

// File: verif/tb_nearest_centroid_classifier_top.sv
// self-checking testbench for nearest_centroid_classifier_top: centroid loads and pixel
// classify requests, labels checked against an in-bench nearest centroid predictor
// depends on ncc_pkg and the nearest_centroid_classifier_top rtl

module tb_nearest_centroid_classifier_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FIELD_W      = ncc_pkg::FIELD_W;
    localparam int IN_COMPS     = ncc_pkg::IN_COMPS;
    localparam int LABEL_W      = ncc_pkg::LABEL_W;
    localparam int INDEX_W      = ncc_pkg::INDEX_W;
    localparam int CFG_INDEX_W  = ncc_pkg::CFG_INDEX_W;
    localparam int CFG_DATA_W   = ncc_pkg::CFG_DATA_W;
    localparam int CLASS_CNT_W  = ncc_pkg::CLASS_CNT_W;
    localparam int COMP_CNT_W   = ncc_pkg::COMP_CNT_W;

    localparam int N_CLASSES    = ncc_pkg::MAX_CLASSES_DEF;
    localparam int N_COMPS      = ncc_pkg::MAX_COMPONENTS_DEF;
    localparam int PHASE_ITEMS  = 115;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PRINT_LIMIT  = 100;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic                          op;
        logic [INDEX_W-1:0]            cls;
        logic [IN_COMPS-1:0][FIELD_W-1:0] comp;
    } t_pixel_req;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic       in_valid  = 1'b0;
    t_pixel_req cur_req   = '0;
    logic       out_ready = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    logic                o_in_ready;
    logic                o_out_valid;
    logic                o_cfg_ready;
    logic [LABEL_W-1:0]  o_class_label;

    t_pixel_req       pixel_requests[$];
    logic [LABEL_W-1:0] predicted_labels[$];

    logic [IN_COMPS-1:0][FIELD_W-1:0] centroid_mem [N_CLASSES];
    logic [CLASS_CNT_W-1:0] class_cnt = '0;
    logic [COMP_CNT_W-1:0]  comp_cnt  = ncc_pkg::COMP_CNT_RESET;

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic hold_req      = 1'b0;
    logic hold_done     = 1'b0;
    int   hold_left     = 0;
    logic in_accepted   = 1'b0;
    int   fail_count    = 0;
    int   cycle_count   = 0;
    logic [LABEL_W-1:0] want_label;

    nearest_centroid_classifier_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_operation   (cur_req.op),
        .i_class_index (cur_req.cls),
        .i_comp0       (cur_req.comp[0]),
        .i_comp1       (cur_req.comp[1]),
        .i_comp2       (cur_req.comp[2]),
        .i_comp3       (cur_req.comp[3]),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_class_label (o_class_label),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    always #2 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        if (fail_count < PRINT_LIMIT) begin
            $display("ERROR at cycle %0d: %s", cycle_count, msg);
        end
        fail_count++;
    endtask

    // squared euclidean distance search, ties keep the lower label
    function automatic logic [LABEL_W-1:0] nearest_label(
        input logic [IN_COMPS-1:0][FIELD_W-1:0] px
    );
        int                 n_cls;
        int                 n_comp;
        logic [LABEL_W-1:0] best;
        logic [35:0]        best_d;
        logic [35:0]        sq_total;
        logic signed [16:0] diff;
        logic signed [35:0] sq;
        n_cls  = (class_cnt > N_CLASSES) ? N_CLASSES : int'(class_cnt);
        n_comp = (comp_cnt > N_COMPS) ? N_COMPS : int'(comp_cnt);
        best   = '0;
        best_d = '1;
        for (int k = 0; k < n_cls; k++) begin
            sq_total = '0;
            for (int j = 0; j < n_comp; j++) begin
                diff     = $signed(px[j]) - $signed(centroid_mem[k][j]);
                sq       = diff * diff;
                sq_total = sq_total + sq;
            end
            if (k == 0 || sq_total < best_d) begin
                best_d = sq_total;
                best   = LABEL_W'(k);
            end
        end
        return best;
    endfunction

    function automatic logic [FIELD_W-1:0] rand_comp();
        case ($urandom_range(9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return FIELD_W'($urandom);
        endcase
    endfunction

    // mostly pixels near a loaded centroid, some exact copies and wild values; about one in five is a load
    function automatic t_pixel_req random_request();
        t_pixel_req r;
        int         k;
        int         mode;
        r.op  = ($urandom_range(99) < 20) ? ncc_pkg::OP_LOAD : ncc_pkg::OP_CLASSIFY;
        r.cls = INDEX_W'($urandom);
        k     = $urandom_range(N_CLASSES - 1);
        mode  = $urandom_range(9);
        for (int j = 0; j < IN_COMPS; j++) begin
            if (mode < 2) begin
                r.comp[j] = centroid_mem[k][j];
            end else if (mode < 7) begin
                r.comp[j] = centroid_mem[k][j] + FIELD_W'($urandom_range(64) - 32);
            end else begin
                r.comp[j] = rand_comp();
            end
        end
        return r;
    endfunction

    task automatic queue_request(
        input logic op, input logic [INDEX_W-1:0] cls,
        input logic [FIELD_W-1:0] c0, input logic [FIELD_W-1:0] c1,
        input logic [FIELD_W-1:0] c2, input logic [FIELD_W-1:0] c3
    );
        t_pixel_req r;
        r.op   = op;
        r.cls  = cls;
        r.comp = {c3, c2, c1, c0};
        pixel_requests.push_back(r);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pixel_requests.size() != 0 || in_valid || predicted_labels.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_random_phase(input logic [CFG_DATA_W-1:0] classes,
                                    input logic [CFG_DATA_W-1:0] comps);
        wait_drained();
        write_reg(ncc_pkg::CFG_CLASS_COUNT, classes);
        write_reg(ncc_pkg::CFG_COMP_COUNT, comps);
        repeat (PHASE_ITEMS) pixel_requests.push_back(random_request());
    endtask

    // request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_accepted) begin
            if (pixel_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                cur_req  <= pixel_requests.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // result receiver with one long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor and predictor
    always @(posedge i_clk) begin
        in_accepted <= in_valid && o_in_ready;
        if (i_rst_n) begin
            if (cfg_valid && o_cfg_ready) begin
                case (cfg_index)
                    ncc_pkg::CFG_CLASS_COUNT: class_cnt = cfg_data[CLASS_CNT_W-1:0];
                    ncc_pkg::CFG_COMP_COUNT:  comp_cnt  = cfg_data[COMP_CNT_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && o_in_ready) begin
                if (cur_req.op == ncc_pkg::OP_LOAD) begin
                    centroid_mem[cur_req.cls] = cur_req.comp;
                end else begin
                    predicted_labels.push_back(nearest_label(cur_req.comp));
                end
            end
            if (o_out_valid && out_ready) begin
                if (predicted_labels.size() == 0) begin
                    report_mismatch($sformatf("label %0d with no classify request waiting",
                                              o_class_label));
                end else begin
                    want_label = predicted_labels.pop_front();
                    if (o_class_label !== want_label) begin
                        report_mismatch($sformatf("class_label %0d, expected %0d",
                                                  o_class_label, want_label));
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        for (int k = 0; k < N_CLASSES; k++) centroid_mem[k] = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 29;
        recv_idle_pct = 74;

        // reset values: no classes, so label 0
        queue_request(ncc_pkg::OP_CLASSIFY, 4'd0, 16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF);
        queue_request(ncc_pkg::OP_LOAD, 4'd0, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        queue_request(ncc_pkg::OP_LOAD, 4'd1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        queue_request(ncc_pkg::OP_LOAD, 4'd2, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        queue_request(ncc_pkg::OP_LOAD, 4'd3, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        queue_request(ncc_pkg::OP_LOAD, 4'd4, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
        queue_request(ncc_pkg::OP_LOAD, 4'd5, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
        for (int k = 6; k < N_CLASSES; k++) begin
            queue_request(ncc_pkg::OP_LOAD, INDEX_W'(k), rand_comp(), rand_comp(),
                          rand_comp(), rand_comp());
        end

        // all classes, extremes and an exact tie between two zero centroids
        wait_drained();
        write_reg(ncc_pkg::CFG_CLASS_COUNT, 5'd16);
        queue_request(ncc_pkg::OP_CLASSIFY, 4'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        queue_request(ncc_pkg::OP_CLASSIFY, 4'd0, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        queue_request(ncc_pkg::OP_CLASSIFY, 4'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        queue_request(ncc_pkg::OP_CLASSIFY, 4'd0, 16'h0001, 16'h0000, 16'hFFFF, 16'h0000);
        queue_request(ncc_pkg::OP_CLASSIFY, 4'd0, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);

        // zero components and class count above the table size
        wait_drained();
        write_reg(ncc_pkg::CFG_CLASS_COUNT, 5'd31);
        write_reg(ncc_pkg::CFG_COMP_COUNT, 5'd0);
        queue_request(ncc_pkg::OP_CLASSIFY, 4'd0, 16'h7FFF, 16'h8000, 16'h1234, 16'hFFFF);
        queue_request(ncc_pkg::OP_CLASSIFY, 4'd15, 16'h8000, 16'h7FFF, 16'h0000, 16'h0001);

        // component count above four, unused register indexes ignored
        wait_drained();
        write_reg(ncc_pkg::CFG_CLASS_COUNT, 5'd17);
        write_reg(ncc_pkg::CFG_COMP_COUNT, 5'd31);
        write_reg(CFG_SPARE_LO, 5'd0);
        write_reg(CFG_SPARE_HI, 5'd31);
        queue_request(ncc_pkg::OP_CLASSIFY, 4'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFE);
        queue_request(ncc_pkg::OP_CLASSIFY, 4'd0, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);

        run_random_phase(5'd16, 5'd4);
        run_random_phase(5'd1, 5'd1);
        run_random_phase(5'd3, 5'd2);

        wait_drained();
        send_idle_pct = 74;
        recv_idle_pct = 29;
        run_random_phase(5'd0, 5'd3);
        run_random_phase(5'd12, 5'b01101);
        run_random_phase(5'd16, 5'd1);

        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_phase(5'd16, 5'd4);
        hold_req = 1'b1;
        run_random_phase(5'd7, 5'b10110);
        run_random_phase(5'd2, 5'd2);

        wait_drained();
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
